FILE: src/cht_pkg.sv
package cht_pkg;

   // Port widths of the item fields
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;

   // Default table geometry
   localparam int BUCKETS_DEF    = 16;
   localparam int POOL_NODES_DEF = 64;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;

   // Operation codes
   localparam logic MODE_PUT = 1'b0;
   localparam logic MODE_GET = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;      // latch the request fields
      logic hash_start;  // start the bucket computation
      logic head_read;   // read the bucket head
      logic walk_head;   // follow the head pointer into node memory
      logic walk_link;   // follow the link of the current node
      logic found;       // current node holds the key
      logic commit;      // update the table and load the result
      logic clear_step;  // clear one bucket head
   } cht_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;  // last bucket head being cleared
      logic hash_done;   // bucket index is ready
      logic head_nil;    // bucket chain is empty
      logic node_match;  // node read data holds the key
      logic link_nil;    // node read data ends the chain
      logic out_free;    // result register can take a new item
   } cht_status_type;

endpackage

FILE: src/chained_hash_table_unit.sv
// Key/value table with separate chaining. Each item is a put (mode 0) or a
// get (mode 1); the bucket is the key modulo BUCKETS, and the block walks
// that bucket's chain in node memory one node per cycle. An item is
// accepted, its bucket index is computed, the bucket head is read, the
// chain is walked node by node and the item is committed. When BUCKETS is
// a power of two the index is the low key bits; otherwise it comes from
// the modulo unit that folds eight key bits per cycle. The result sits in an
// output register, so the next item is taken while it waits; commit stalls
// only when the previous result has not yet been taken. After reset the
// block clears every bucket head before it takes an item.
module chained_hash_table_unit #(
   parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
   parameter int POOL_NODES = cht_pkg::POOL_NODES_DEF,
   parameter int KEY_BITS   = cht_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic [cht_pkg::KEY_W-1:0]   req_key,
   input  logic [cht_pkg::VALUE_W-1:0] req_value_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_ok,
   output logic                        rsp_hit,
   output logic [cht_pkg::VALUE_W-1:0] rsp_value_out,
   output logic [cht_pkg::COUNT_W-1:0] rsp_entry_count
);

   import cht_pkg::*;

   cht_cmd_type    cmd;
   cht_status_type status;

   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cht_dp #(
      .BUCKETS    (BUCKETS),
      .POOL_NODES (POOL_NODES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_mode),
      .req_key         (req_key),
      .req_value_in    (req_value_in),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_hit         (rsp_hit),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

FILE: src/cht_ram.sv
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, registered read port that holds its data between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/cht_hash.sv
module cht_hash #(
   parameter int KEY_BITS = 32,
   parameter int BUCKETS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [KEY_BITS-1:0]        key,
   output logic                       done,
   output logic [$clog2(BUCKETS)-1:0] bucket
);

   import cht_pkg::*;

   localparam int  SB       = $clog2(BUCKETS);
   localparam int  XW       = (KEY_BITS > SB) ? KEY_BITS : SB;
   localparam bit  IS_POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

   logic [XW-1:0] key_ext;

   assign key_ext = XW'(key);

   if (IS_POW2) begin : g_mask
      logic          done_ff;
      logic [SB-1:0] bucket_ff;

      // Register the low key bits as the bucket index
      always_ff @(posedge clock) begin
         if (reset) begin
            done_ff <= 1'b0;
         end else if (start) begin
            done_ff <= 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (start) begin
            bucket_ff <= key_ext[SB-1:0];
         end
      end

      assign done   = done_ff;
      assign bucket = bucket_ff;
   end else begin : g_digit
      localparam int          PW     = ((XW + 7) / 8) * 8;
      localparam int          DIGITS = PW / 8;
      localparam int          CW     = $clog2(DIGITS + 1);
      localparam logic [SB:0] BMOD   = (SB + 1)'(BUCKETS);

      logic [PW-1:0] sh_ff;
      logic [SB-1:0] rem_ff;
      logic [CW-1:0] cnt_ff;
      logic          done_ff;

      // Fold eight key bits into the running remainder
      function automatic logic [SB-1:0] rem_digit(input logic [SB-1:0] r,
                                                  input logic [7:0]    d);
         logic [SB:0]   t;
         logic [SB-1:0] acc;
         acc = r;
         for (int i = 7; i >= 0; i--) begin
            t = {acc, d[i]};
            if (t >= BMOD) begin
               t = t - BMOD;
            end
            acc = t[SB-1:0];
         end
         return acc;
      endfunction

      // Count the digits down, most significant digit first
      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff  <= '0;
            done_ff <= 1'b0;
         end else if (start) begin
            cnt_ff  <= CW'(DIGITS);
            done_ff <= 1'b0;
         end else if (cnt_ff != '0) begin
            cnt_ff <= CW'(cnt_ff - 1'b1);
            if (cnt_ff == CW'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (start) begin
            sh_ff  <= PW'(key_ext);
            rem_ff <= '0;
         end else if (cnt_ff != '0) begin
            sh_ff  <= sh_ff << 8;
            rem_ff <= rem_digit(rem_ff, sh_ff[PW-1 -: 8]);
         end
      end

      assign done   = done_ff;
      assign bucket = rem_ff;
   end

endmodule

FILE: src/cht_ctrl.sv
module cht_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cht_pkg::cht_status_type status,
   output cht_pkg::cht_cmd_type    cmd
);

   import cht_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_HASH   = 6'b000100,
      ST_HEAD   = 6'b001000,
      ST_NODE   = 6'b010000,
      ST_FINISH = 6'b100000
   } cht_state_type;

   cht_state_type state_ff;
   cht_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Clear the bucket heads after reset, then sequence each item: accept, hash, head read, chain walk, commit
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept     = 1'b1;
               cmd.hash_start = 1'b1;
               state_in       = ST_HASH;
            end
         end
         ST_HASH: begin
            if (status.hash_done) begin
               cmd.head_read = 1'b1;
               state_in      = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (status.head_nil) begin
               state_in = ST_FINISH;
            end else begin
               cmd.walk_head = 1'b1;
               state_in      = ST_NODE;
            end
         end
         ST_NODE: begin
            if (status.node_match) begin
               cmd.found = 1'b1;
               state_in  = ST_FINISH;
            end else if (status.link_nil) begin
               state_in = ST_FINISH;
            end else begin
               cmd.walk_link = 1'b1;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

FILE: src/cht_dp.sv
module cht_dp #(
   parameter int BUCKETS    = 16,
   parameter int POOL_NODES = 64,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cht_pkg::cht_cmd_type          cmd,
   output cht_pkg::cht_status_type       status,
   input  logic                          req_mode,
   input  logic [cht_pkg::KEY_W-1:0]     req_key,
   input  logic [cht_pkg::VALUE_W-1:0]   req_value_in,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_ok,
   output logic                          rsp_hit,
   output logic [cht_pkg::VALUE_W-1:0]   rsp_value_out,
   output logic [cht_pkg::COUNT_W-1:0]   rsp_entry_count
);

   import cht_pkg::*;

   localparam int          KW     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int          VW     = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
   localparam int          NW     = $clog2(POOL_NODES + 1);
   localparam int          AW     = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int          SB     = $clog2(BUCKETS);
   localparam int          NODE_W = KW + VW + NW;
   localparam logic [NW-1:0] NIL  = NW'(POOL_NODES);

   // Request and walk registers
   logic          mode_ff;
   logic [KW-1:0] key_ff;
   logic [VW-1:0] value_ff;
   logic [AW-1:0] cur_ff;
   logic          hit_ff;
   logic [NW-1:0] used_ff;
   logic [NW-1:0] used_in;
   logic [SB-1:0] clr_ff;

   // Result register
   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic               rsp_hit_ff;
   logic [VALUE_W-1:0] rsp_value_out_ff;
   logic [COUNT_W-1:0] rsp_entry_count_ff;

   logic          hash_done;
   logic [SB-1:0] bucket;

   logic          head_we;
   logic [SB-1:0] head_waddr;
   logic [NW-1:0] head_wdata;
   logic [NW-1:0] head_q;

   logic              node_we;
   logic              node_re;
   logic [AW-1:0]     node_waddr;
   logic [AW-1:0]     node_raddr;
   logic [NODE_W-1:0] node_wdata;
   logic [NODE_W-1:0] node_q;
   logic [KW-1:0]     node_key_q;
   logic [VW-1:0]     node_value_q;
   logic [NW-1:0]     node_link_q;

   logic is_get;
   logic pool_free;
   logic do_update;
   logic do_insert;

   cht_hash #(
      .KEY_BITS (KW),
      .BUCKETS  (BUCKETS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.hash_start),
      .key    (req_key[KW-1:0]),
      .done   (hash_done),
      .bucket (bucket)
   );

   cht_ram #(
      .WIDTH (NW),
      .DEPTH (BUCKETS)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_en   (cmd.head_read),
      .rd_addr (bucket),
      .rd_data (head_q)
   );

   cht_ram #(
      .WIDTH (NODE_W),
      .DEPTH (POOL_NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_en   (node_re),
      .rd_addr (node_raddr),
      .rd_data (node_q)
   );

   // Split the node word
   assign node_key_q   = node_q[NODE_W-1 -: KW];
   assign node_value_q = node_q[NW +: VW];
   assign node_link_q  = node_q[NW-1:0];

   // Decide what the commit does
   assign is_get    = (mode_ff == MODE_GET);
   assign pool_free = (used_ff != NIL);
   assign do_update = !is_get && hit_ff;
   assign do_insert = !is_get && !hit_ff && pool_free;

   // Head writes: clearing pass, or link a new node at the chain head
   assign head_we    = cmd.clear_step || (cmd.commit && do_insert);
   assign head_waddr = cmd.clear_step ? clr_ff : bucket;
   assign head_wdata = cmd.clear_step ? NIL : used_ff;

   // Node reads follow the head pointer or the current link
   assign node_re    = cmd.walk_head || cmd.walk_link;
   assign node_raddr = cmd.walk_head ? head_q[AW-1:0] : node_link_q[AW-1:0];

   // Node writes: replace the value in place, or fill the next free node
   assign node_we    = cmd.commit && (do_update || do_insert);
   assign node_waddr = do_update ? cur_ff : used_ff[AW-1:0];
   assign node_wdata = do_update ? {node_key_q, value_ff, node_link_q}
                                 : {key_ff, value_ff, head_q};

   assign used_in = (cmd.commit && do_insert) ? NW'(used_ff + 1'b1) : used_ff;

   // Latch the request and track the walk
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key[KW-1:0];
         value_ff <= req_value_in[VW-1:0];
      end
      if (cmd.walk_head || cmd.walk_link) begin
         cur_ff <= node_raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         used_ff <= '0;
         clr_ff  <= '0;
      end else begin
         if (cmd.accept) begin
            hit_ff <= 1'b0;
         end else if (cmd.found) begin
            hit_ff <= 1'b1;
         end
         used_ff <= used_in;
         if (cmd.clear_step) begin
            clr_ff <= SB'(clr_ff + 1'b1);
         end
      end
   end

   // Result register: load on commit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ok_ff          <= is_get || hit_ff || pool_free;
         rsp_hit_ff         <= hit_ff;
         rsp_value_out_ff   <= (is_get && hit_ff) ? VALUE_W'(node_value_q) : '0;
         rsp_entry_count_ff <= COUNT_W'(used_in);
      end
   end

   assign status.clear_last = (clr_ff == SB'(BUCKETS - 1));
   assign status.hash_done  = hash_done;
   assign status.head_nil   = (head_q == NIL);
   assign status.node_match = (node_key_q == key_ff);
   assign status.link_nil   = (node_link_q == NIL);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_value_out   = rsp_value_out_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

FILE: tb/tb_chained_hash_table_unit.sv
`timescale 1ns / 1ps

module tb_chained_hash_table_unit;
   import cht_pkg::*;

   localparam int BUCKETS     = BUCKETS_DEF;
   localparam int POOL_NODES  = POOL_NODES_DEF;
   localparam int NIL_NODE    = POOL_NODES;
   localparam int KEY_SET     = 48;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 120;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic               ok;
      logic               hit;
      logic [VALUE_W-1:0] value_out;
      logic [COUNT_W-1:0] entry_count;
   } table_answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_mode = MODE_PUT;
   logic [KEY_W-1:0]   req_key = '0;
   logic [VALUE_W-1:0] req_value_in = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_ok;
   logic               rsp_hit;
   logic [VALUE_W-1:0] rsp_value_out;
   logic [COUNT_W-1:0] rsp_entry_count;

   // Shadow copy of the table
   int                 chain_head [BUCKETS];
   logic [KEY_W-1:0]   shadow_key [POOL_NODES];
   logic [VALUE_W-1:0] shadow_value [POOL_NODES];
   int                 shadow_link [POOL_NODES];
   int                 nodes_taken;

   table_answer_type   table_answers [$];
   logic [KEY_W-1:0]   key_set [KEY_SET];
   int unsigned        mismatch_count = 0;
   int unsigned        cycle_count = 0;
   int unsigned        send_idle_pct = 0;
   int unsigned        recv_stall_pct = 0;
   int unsigned        hold_seq = 0;
   int unsigned        hold_seen = 0;
   int unsigned        hold_left = 0;

   chained_hash_table_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_hit        (rsp_hit),
      .rsp_value_out  (rsp_value_out),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Walk a bucket chain; return the node holding key or NIL_NODE
   function automatic int find_node(input logic [KEY_W-1:0] key);
      int cur;
      int steps;
      int found;
      cur = chain_head[key % BUCKETS];
      steps = 0;
      found = NIL_NODE;
      while (found == NIL_NODE && cur < NIL_NODE && steps < POOL_NODES) begin
         if (shadow_key[cur] == key) found = cur;
         else cur = shadow_link[cur];
         steps++;
      end
      return found;
   endfunction

   // Apply one put or get to the shadow table and form its answer
   function automatic table_answer_type table_access(input logic mode,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [VALUE_W-1:0] val);
      table_answer_type ans;
      int node;
      int bucket;
      node = find_node(key);
      bucket = key % BUCKETS;
      ans.ok = 1'b1;
      ans.hit = (node < NIL_NODE);
      ans.value_out = '0;
      if (mode == MODE_GET) begin
         if (ans.hit) ans.value_out = shadow_value[node];
      end else if (ans.hit) begin
         shadow_value[node] = val;
      end else if (nodes_taken < POOL_NODES) begin
         shadow_key[nodes_taken] = key;
         shadow_value[nodes_taken] = val;
         shadow_link[nodes_taken] = chain_head[bucket];
         chain_head[bucket] = nodes_taken;
         nodes_taken++;
      end else begin
         ans.ok = 1'b0;
      end
      ans.entry_count = nodes_taken[COUNT_W-1:0];
      return ans;
   endfunction

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input logic mode, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] val);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_key      <= key;
      req_value_in <= val;
      do @(posedge clock); while (!(req_valid && req_ready));
      table_answers.push_back(table_access(mode, key, val));
   endtask

   // Drop valid and wait until every answer has come back
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (table_answers.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Compare one accepted result with the oldest answer
   task automatic check_answer();
      table_answer_type want;
      if (table_answers.size() == 0) begin
         $error("result with no item outstanding");
         mismatch_count++;
      end else begin
         want = table_answers.pop_front();
         if (rsp_ok !== want.ok) begin
            $error("rsp_ok: expected %0d, got %0d", want.ok, rsp_ok);
            mismatch_count++;
         end
         if (rsp_hit !== want.hit) begin
            $error("rsp_hit: expected %0d, got %0d", want.hit, rsp_hit);
            mismatch_count++;
         end
         if (rsp_value_out !== want.value_out) begin
            $error("rsp_value_out: expected %h, got %h", want.value_out, rsp_value_out);
            mismatch_count++;
         end
         if (rsp_entry_count !== want.entry_count) begin
            $error("rsp_entry_count: expected %0d, got %0d",
                   want.entry_count, rsp_entry_count);
            mismatch_count++;
         end
      end
   endtask

   // Drive ready, hold it off on request, check each accepted result
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      if (!reset && rsp_valid && rsp_ready) check_answer();
   end

   // Mix of keys: a third share one bucket to build a long chain
   task automatic build_key_set();
      logic [KEY_W-1:0] r;
      logic [3:0] b;
      for (int i = 0; i < KEY_SET; i++) begin
         r = $urandom();
         b = (i % 3 == 0) ? 4'd5 : 4'($urandom_range(15));
         key_set[i] = {r[KEY_W-1:4], b};
      end
   endtask

   task automatic test_put_get_extremes();
      send_item(MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(MODE_GET, 32'h0000_0000, 32'h0000_0000);
      // stored zero must still report a hit
      send_item(MODE_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(MODE_GET, 32'h0000_0001, 32'hA5A5_5A5A);
   endtask

   task automatic test_update();
      send_item(MODE_PUT, 32'h0000_0000, 32'h1234_5678);
      send_item(MODE_GET, 32'h0000_0000, 32'h0000_0000);
      send_item(MODE_PUT, 32'hFFFF_FFFF, 32'h8000_0001);
      send_item(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   // Several keys in one bucket: hits at every depth and a full-walk miss
   task automatic test_chain_collisions();
      logic [KEY_W-1:0] keys [5];
      keys = '{32'h0000_0003, 32'h0000_0013, 32'h0000_0023,
               32'h8000_0003, 32'hFFFF_FFF3};
      foreach (keys[i]) send_item(MODE_PUT, keys[i], 32'hC000_0000 | i);
      foreach (keys[i]) send_item(MODE_GET, keys[i], '0);
      send_item(MODE_GET, 32'h0000_0033, '0);
      send_item(MODE_PUT, keys[2], 32'h5555_AAAA);
      send_item(MODE_GET, keys[2], '0);
   endtask

   task automatic test_random_traffic(input int n);
      logic mode;
      logic [KEY_W-1:0] key;
      logic [VALUE_W-1:0] val;
      int pick;
      for (int i = 0; i < n; i++) begin
         mode = 1'($urandom_range(1));
         key = ($urandom_range(99) < 8) ? $urandom() : key_set[$urandom_range(KEY_SET - 1)];
         pick = $urandom_range(19);
         if (pick == 0) val = '0;
         else if (pick == 1) val = '1;
         else val = $urandom();
         send_item(mode, key, val);
      end
   endtask

   // Stall the result side long enough to back up the input
   task automatic test_backpressure();
      set_idling(0, 0);
      hold_seq++;
      test_random_traffic(16);
      wait_for_answers();
   endtask

   // Fill the pool, then a new key must fail and leave the table alone
   task automatic test_pool_exhaustion();
      logic [KEY_W-1:0] key;
      set_idling(32, 32);
      while (nodes_taken < POOL_NODES) begin
         do key = $urandom(); while (find_node(key) != NIL_NODE);
         send_item(MODE_PUT, key, $urandom());
      end
      do key = $urandom(); while (find_node(key) != NIL_NODE);
      send_item(MODE_PUT, key, 32'hDEAD_BEEF);
      send_item(MODE_GET, key, '0);
      send_item(MODE_PUT, 32'h0000_0000, 32'h0BAD_F00D);
      send_item(MODE_GET, 32'h0000_0000, '0);
      wait_for_answers();
   endtask

   initial begin
      for (int i = 0; i < BUCKETS; i++) chain_head[i] = NIL_NODE;
      for (int i = 0; i < POOL_NODES; i++) shadow_link[i] = NIL_NODE;
      nodes_taken = 0;
      build_key_set();

      // hold reset, then release
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_put_get_extremes();
      test_update();
      test_chain_collisions();
      wait_for_answers();

      set_idling(0, 0);
      test_random_traffic(160);
      wait_for_answers();
      set_idling(69, 0);
      test_random_traffic(160);
      wait_for_answers();
      set_idling(0, 69);
      test_random_traffic(160);
      wait_for_answers();
      set_idling(32, 32);
      test_random_traffic(160);
      wait_for_answers();

      test_backpressure();
      test_pool_exhaustion();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && table_answers.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
